// ===== rtl/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants for the accelerometer step counter
// Register indexes, command codes, reset values and bus layout constants.
// ----------------------------------------------------------------------------
package asc_pkg;

    // default widths of the sample and time fields actually used
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    // bus layout
    localparam int AXIS_FIELD_W = 16;
    localparam int TIME_FIELD_W = 32;
    localparam int NUM_AXES     = 3;
    localparam int IN_DATA_W    = NUM_AXES * AXIS_FIELD_W + TIME_FIELD_W;
    localparam int TIME_LSB     = NUM_AXES * AXIS_FIELD_W;
    localparam int STEP_W       = 32;
    localparam int OUT_DATA_W   = 40;
    localparam int OUT_PAD_W    = OUT_DATA_W - STEP_W - 4;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int BAND_W      = 16;
    localparam int WIN_W       = 8;

    // peak tracker reset value and the signed width it needs
    localparam int PEAK_INIT   = 4096;
    localparam int PEAK_INIT_W = $clog2(PEAK_INIT) + 2;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLED        = 3'd0,
        REG_PRECISION_BAND = 3'd1,
        REG_MIN_STEP       = 3'd2,
        REG_MAX_STEP       = 3'd3,
        REG_WINDOW_LIMIT   = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic              enabled;
        logic [BAND_W-1:0] precision_band;
        logic [BAND_W-1:0] min_step_interval;
        logic [BAND_W-1:0] max_step_interval;
        logic [WIN_W-1:0]  window_limit;
    } cfg_t;

    localparam logic              RST_ENABLED    = 1'b1;
    localparam logic [BAND_W-1:0] RST_BAND       = 16'd100;
    localparam logic [BAND_W-1:0] RST_MIN_STEP   = 16'd350;
    localparam logic [BAND_W-1:0] RST_MAX_STEP   = 16'd2000;
    localparam logic [WIN_W-1:0]  RST_WIN_LIMIT  = 8'd50;

endpackage

// ===== rtl/accel_step_counter.sv =====
// ----------------------------------------------------------------------------
// Path: the fourth reading of a group is written into the queue when it is
//   accepted, then passes stage A and the result register before m_tvalid rises.
// Throughput: one transaction per cycle, in and out; s_tready drops only while
//   the 4-entry queue is full behind a stalled result stream.
// Reset: aresetn synchronous active low; restores register defaults and all
//   tracker state at once; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// accel_step_counter: accelerometer driven step counter, top level
// Configuration registers, front (averaging), queue and back (step logic).
// ----------------------------------------------------------------------------
module accel_step_counter #(
    parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = asc_pkg::TIME_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [asc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [asc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [asc_pkg::IN_DATA_W-1:0]   s_tdata,  // accel_x, accel_y, accel_z, now_ms
    input  logic                            s_tuser,  // operation
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [asc_pkg::OUT_DATA_W-1:0]  m_tdata   // step_total, step_accepted,
                                                      // candidate_seen, dominant_axis
);

    localparam int ENTRY_W = 1 + asc_pkg::NUM_AXES * SAMPLE_BITS + TIME_BITS;

    asc_pkg::cfg_t   cfg_reg, cfg_next;
    logic            q_push, q_full, q_empty, q_pop;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                asc_pkg::REG_ENABLED:        cfg_next.enabled = cfg_wdata[0];
                asc_pkg::REG_PRECISION_BAND: cfg_next.precision_band = cfg_wdata;
                asc_pkg::REG_MIN_STEP:       cfg_next.min_step_interval = cfg_wdata;
                asc_pkg::REG_MAX_STEP:       cfg_next.max_step_interval = cfg_wdata;
                asc_pkg::REG_WINDOW_LIMIT:
                    cfg_next.window_limit = cfg_wdata[asc_pkg::WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enabled           <= asc_pkg::RST_ENABLED;
            cfg_reg.precision_band    <= asc_pkg::RST_BAND;
            cfg_reg.min_step_interval <= asc_pkg::RST_MIN_STEP;
            cfg_reg.max_step_interval <= asc_pkg::RST_MAX_STEP;
            cfg_reg.window_limit      <= asc_pkg::RST_WIN_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    asc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .enabled   (cfg_reg.enabled),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_data    (q_wdata)
    );

    asc_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (asc_pkg::FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    asc_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/asc_fifo.sv =====
// ----------------------------------------------------------------------------
// asc_fifo: small register queue between the front and the back
// Single clock, push and pop in the same cycle allowed, show-ahead read.
// ----------------------------------------------------------------------------
module asc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = asc_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/asc_front.sv =====
// ----------------------------------------------------------------------------
// asc_front: input side of the step counter
// Accepts transactions, accumulates four readings per axis, forms the
// truncated averages and queues averages and clear commands in order.
// ----------------------------------------------------------------------------
module asc_front #(
    parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = asc_pkg::TIME_BITS_DEF,
    parameter int ENTRY_W     = 1 + asc_pkg::NUM_AXES * SAMPLE_BITS + TIME_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [asc_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  logic                         enabled,
    output logic                         q_push,
    input  logic                         q_full,
    output logic [ENTRY_W-1:0]           q_data
);

    localparam int SUM_W = SAMPLE_BITS + 2;

    logic signed [SUM_W-1:0]       sum_reg  [asc_pkg::NUM_AXES];
    logic signed [SUM_W-1:0]       sum_next [asc_pkg::NUM_AXES];
    logic signed [SUM_W-1:0]       sum_add  [asc_pkg::NUM_AXES];
    logic signed [SUM_W-1:0]       sum_bias [asc_pkg::NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] sample   [asc_pkg::NUM_AXES];
    logic [1:0]                    idx_reg, idx_next;
    logic                          accept, is_clear, group_done;
    logic [TIME_BITS-1:0]          now;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign is_clear   = (asc_pkg::op_t'(s_tuser) == asc_pkg::OP_CLEAR);
    assign group_done = (idx_reg == 2'd3);
    assign now        = s_tdata[asc_pkg::TIME_LSB +: TIME_BITS];

    always_comb begin
        q_push    = 1'b0;
        idx_next  = idx_reg;
        q_data    = '0;
        q_data[0] = is_clear;
        q_data[1 + asc_pkg::NUM_AXES*SAMPLE_BITS +: TIME_BITS] = now;
        for (int i = 0; i < asc_pkg::NUM_AXES; i++) begin
            sample[i]   = s_tdata[i*asc_pkg::AXIS_FIELD_W +: SAMPLE_BITS];
            sum_add[i]  = sum_reg[i] + SUM_W'(sample[i]);
            sum_next[i] = sum_reg[i];
            // divide by four toward zero: bias negative sums by three first
            sum_bias[i] = sum_add[i] + {{(SUM_W-2){1'b0}},
                                        sum_add[i][SUM_W-1], sum_add[i][SUM_W-1]};
            q_data[1 + i*SAMPLE_BITS +: SAMPLE_BITS] = sum_bias[i][SUM_W-1:2];
        end
        if (accept) begin
            if (is_clear) begin
                q_push = 1'b1;
            end else if (enabled) begin
                idx_next = idx_reg + 1'b1;
                for (int i = 0; i < asc_pkg::NUM_AXES; i++) begin
                    sum_next[i] = group_done ? '0 : sum_add[i];
                end
                q_push = group_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            for (int i = 0; i < asc_pkg::NUM_AXES; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            idx_reg <= idx_next;
            for (int i = 0; i < asc_pkg::NUM_AXES; i++) begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

endmodule

// ===== rtl/asc_back.sv =====
// ----------------------------------------------------------------------------
// asc_back: execution side of the step counter
// Stage A updates peaks, thresholds and filtered values per average.
// Stage B picks the dominant axis, detects crossings and counts steps,
// then loads the result register; a clear command only zeroes the step count.
// ----------------------------------------------------------------------------
module asc_back #(
    parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = asc_pkg::TIME_BITS_DEF,
    parameter int ENTRY_W     = 1 + asc_pkg::NUM_AXES * SAMPLE_BITS + TIME_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  asc_pkg::cfg_t                 cfg,
    input  logic                          q_empty,
    input  logic [ENTRY_W-1:0]            q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [asc_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int NA    = asc_pkg::NUM_AXES;
    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = (SB > asc_pkg::PEAK_INIT_W - 1) ? SB : asc_pkg::PEAK_INIT_W;
    localparam int DW    = SB + 1;
    localparam int CMP_W = (DW > asc_pkg::BAND_W) ? DW : asc_pkg::BAND_W;
    localparam int WW    = asc_pkg::WIN_W;

    // ---------------- stage A ----------------
    logic signed [PW-1:0] peak_high_reg [NA], peak_high_next [NA];
    logic signed [PW-1:0] peak_low_reg  [NA], peak_low_next  [NA];
    logic        [PW-1:0] abs_peak_reg  [NA], abs_peak_next  [NA];
    logic signed [PW-1:0] thr_reg       [NA], thr_next       [NA];
    logic signed [SB-1:0] filt_reg      [NA], filt_next      [NA];
    logic [WW-1:0]        avg_cnt_reg, avg_cnt_next, avg_cnt_inc;

    logic signed [SB-1:0] avg   [NA];
    logic signed [PW-1:0] avg_w [NA];
    logic signed [PW-1:0] hi1   [NA];
    logic signed [PW-1:0] lo1   [NA];
    logic        [PW-1:0] mag_h [NA];
    logic        [PW-1:0] mag_l [NA];
    logic signed [PW:0]   hl_sum [NA];
    logic signed [DW-1:0] diff  [NA];
    logic        [DW-1:0] adiff [NA];
    logic                 changed, refresh, in_clear;
    logic [TIME_BITS-1:0] in_now;

    // stage A/B register
    logic                 a_valid_reg, a_valid_next;
    logic                 a_clear_reg;
    logic [TIME_BITS-1:0] a_now_reg;
    logic signed [SB-1:0] a_prev_reg [NA];
    logic                 a_take, a_load;

    // ---------------- stage B ----------------
    logic [TIME_BITS-1:0]        last_time_reg, last_time_next;
    logic [asc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        o_valid_reg, o_valid_next;
    logic [asc_pkg::OUT_DATA_W-1:0] o_data_reg, o_data_next;
    logic                        o_ready;
    asc_pkg::axis_t              axis;
    logic signed [PW-1:0]        sel_thr, sel_prev, sel_filt;
    logic [TIME_BITS-1:0]        gap;
    logic                        candidate, in_window, accepted;

    assign in_clear = q_data[0];
    assign in_now   = q_data[1 + NA*SB +: TIME_BITS];

    assign o_ready  = !o_valid_reg || m_tready;
    assign a_take   = a_valid_reg && (a_clear_reg || o_ready);
    assign a_load   = !a_valid_reg || a_take;
    assign q_pop    = a_load && !q_empty;

    // stage A: state reflects the item sitting in the stage register
    always_comb begin
        changed     = 1'b0;
        avg_cnt_inc = avg_cnt_reg + 1'b1;
        refresh     = (avg_cnt_inc > cfg.window_limit);
        for (int i = 0; i < NA; i++) begin
            avg[i]   = q_data[1 + i*SB +: SB];
            avg_w[i] = PW'(avg[i]);
            hi1[i]   = (avg_w[i] > peak_high_reg[i]) ? avg_w[i] : peak_high_reg[i];
            lo1[i]   = (avg_w[i] < peak_low_reg[i])  ? avg_w[i] : peak_low_reg[i];
            if ((avg_w[i] > peak_high_reg[i]) || (avg_w[i] < peak_low_reg[i])) begin
                changed = 1'b1;
            end
            mag_h[i]  = hi1[i][PW-1] ? PW'(-hi1[i]) : PW'(hi1[i]);
            mag_l[i]  = lo1[i][PW-1] ? PW'(-lo1[i]) : PW'(lo1[i]);
            hl_sum[i] = (PW+1)'(hi1[i]) + (PW+1)'(lo1[i]);
            diff[i]   = DW'(filt_reg[i]) - DW'(avg[i]);
            adiff[i]  = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
        end

        avg_cnt_next = avg_cnt_reg;
        for (int i = 0; i < NA; i++) begin
            peak_high_next[i] = peak_high_reg[i];
            peak_low_next[i]  = peak_low_reg[i];
            abs_peak_next[i]  = abs_peak_reg[i];
            thr_next[i]       = thr_reg[i];
            filt_next[i]      = filt_reg[i];
        end

        if (q_pop && !in_clear) begin
            avg_cnt_next = refresh ? '0 : avg_cnt_inc;
            for (int i = 0; i < NA; i++) begin
                if (changed) begin
                    abs_peak_next[i] = (mag_h[i] > mag_l[i]) ? mag_h[i] : mag_l[i];
                end
                if (refresh) begin
                    thr_next[i]       = hl_sum[i][PW:1];  // floor of half
                    peak_high_next[i] = avg_w[i];
                    peak_low_next[i]  = avg_w[i];
                end else begin
                    peak_high_next[i] = hi1[i];
                    peak_low_next[i]  = lo1[i];
                end
                if (CMP_W'(adiff[i]) > CMP_W'(cfg.precision_band)) begin
                    filt_next[i] = avg[i];
                end
            end
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_load) begin
            a_valid_next = !q_empty;
        end
    end

    // stage B: dominant axis, crossing and interval check
    always_comb begin
        if ((abs_peak_reg[0] > abs_peak_reg[1]) && (abs_peak_reg[0] > abs_peak_reg[2])) begin
            axis = asc_pkg::AXIS_X;
        end else if ((abs_peak_reg[1] > abs_peak_reg[0])
                     && (abs_peak_reg[1] > abs_peak_reg[2])) begin
            axis = asc_pkg::AXIS_Y;
        end else begin
            axis = asc_pkg::AXIS_Z;
        end

        sel_thr   = thr_reg[axis];
        sel_prev  = PW'(a_prev_reg[axis]);
        sel_filt  = PW'(filt_reg[axis]);
        candidate = (sel_prev > sel_thr) && (sel_filt < sel_thr);
        gap       = a_now_reg - last_time_reg;
        in_window = (gap >= TIME_BITS'(cfg.min_step_interval))
                    && (gap <= TIME_BITS'(cfg.max_step_interval));
        accepted  = candidate && in_window;

        last_time_next = last_time_reg;
        step_next      = step_reg;
        o_valid_next   = o_valid_reg && !m_tready;
        o_data_next    = o_data_reg;

        if (a_take) begin
            if (a_clear_reg) begin
                step_next = '0;
            end else begin
                if (candidate) begin
                    last_time_next = a_now_reg;
                end
                if (accepted) begin
                    step_next = step_reg + 1'b1;
                end
                o_valid_next = 1'b1;
                o_data_next  = {{asc_pkg::OUT_PAD_W{1'b0}}, axis, candidate, accepted,
                                (accepted ? step_reg + 1'b1 : step_reg)};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_cnt_reg   <= '0;
            a_valid_reg   <= 1'b0;
            last_time_reg <= '0;
            step_reg      <= '0;
            o_valid_reg   <= 1'b0;
            for (int i = 0; i < NA; i++) begin
                peak_high_reg[i] <= -PW'(asc_pkg::PEAK_INIT);
                peak_low_reg[i]  <= PW'(asc_pkg::PEAK_INIT);
                abs_peak_reg[i]  <= '0;
                thr_reg[i]       <= '0;
                filt_reg[i]      <= '0;
            end
        end else begin
            avg_cnt_reg   <= avg_cnt_next;
            a_valid_reg   <= a_valid_next;
            last_time_reg <= last_time_next;
            step_reg      <= step_next;
            o_valid_reg   <= o_valid_next;
            for (int i = 0; i < NA; i++) begin
                peak_high_reg[i] <= peak_high_next[i];
                peak_low_reg[i]  <= peak_low_next[i];
                abs_peak_reg[i]  <= abs_peak_next[i];
                thr_reg[i]       <= thr_next[i];
                filt_reg[i]      <= filt_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        o_data_reg <= o_data_next;
        if (q_pop) begin
            a_clear_reg <= in_clear;
            a_now_reg   <= in_now;
            for (int i = 0; i < NA; i++) begin
                a_prev_reg[i] <= filt_reg[i];
            end
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

endmodule

// ===== rtl/asc_checker.sv =====
// ----------------------------------------------------------------------------
// asc_checker: port level checks for the step counter
// Watches the result stream of the top level; attached by bind.
// ----------------------------------------------------------------------------
module asc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [asc_pkg::OUT_DATA_W-1:0] m_tdata
);

    // a stalled result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a counted step always comes from a crossing
    a_step_needs_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33] || !m_tdata[32]))
        else $error("step accepted without candidate");

    // axis code in range and pad bits clear
    a_axis_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35:34] != 2'd3) && (m_tdata[39:36] == 4'd0))
        else $error("bad axis code or pad bits");

    // nothing is presented right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind accel_step_counter asc_checker u_asc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
